@@ hw/rtl/sii_pkg.sv @@
package sii_pkg;

    localparam int NUM_LANES  = 4;
    localparam int ACC_W      = 68;
    localparam int OPND_W     = 33;
    localparam int PROD_W     = 2 * OPND_W;
    localparam int ITERS      = 32;
    localparam int ITER_W     = $clog2(ITERS);
    localparam int CFG_IDX_W  = 4;

    localparam logic signed [ACC_W-1:0] GRAVITY_Q16 = 68'sd642908;
    localparam logic signed [ACC_W-1:0] ONE_Q60     = 68'sd1152921504606846976;
    localparam logic [31:0]             ONE_Q30     = 32'd1073741824;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_TIME   = 4'd0,
        REG_START_POS_X = 4'd1,
        REG_START_POS_Y = 4'd2,
        REG_START_POS_Z = 4'd3,
        REG_START_VEL_X = 4'd4,
        REG_START_VEL_Y = 4'd5,
        REG_START_VEL_Z = 4'd6,
        REG_START_ATT   = 4'd7
    } cfg_reg_t;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    typedef struct packed {
        logic               first_sample;
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic [31:0]        time_tag;
    } in_beat_t;

    typedef struct packed {
        logic [31:0]        out_time_tag;
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic signed [47:0] pos_z;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] quat_w;
    } out_beat_t;

    typedef enum logic [2:0] {
        SH_NONE,
        SH_19,
        SH_30,
        SH_32,
        SH_33
    } shift_t;

    typedef struct packed {
        logic   valid;
        logic   load;
        logic   neg;
        shift_t shift;
    } lane_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } top_state_t;

    typedef enum logic [1:0] {
        N_IDLE,
        N_SQRT,
        N_DSET,
        N_DIV
    } norm_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        if (x > 68'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -68'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [ACC_W-1:0] x);
        if (x > 68'sd140737488355327)
            return 48'sh7fffffffffff;
        else if (x < -68'sd140737488355328)
            return 48'sh800000000000;
        else
            return x[47:0];
    endfunction

    function automatic logic signed [OPND_W-1:0] s33(input logic signed [31:0] x);
        return {x[31], x};
    endfunction

    function automatic logic signed [OPND_W-1:0] u33(input logic [31:0] x);
        return {1'b0, x};
    endfunction

    function automatic logic signed [ACC_W-1:0] ext32(input logic signed [31:0] x);
        return {{(ACC_W-32){x[31]}}, x};
    endfunction

    function automatic logic signed [ACC_W-1:0] ext48(input logic signed [47:0] x);
        return {{(ACC_W-48){x[47]}}, x};
    endfunction

    function automatic lane_op_t mk_op(input logic load, input logic neg, input shift_t sh);
        lane_op_t op;
        op.valid = 1'b1;
        op.load  = load;
        op.neg   = neg;
        op.shift = sh;
        return op;
    endfunction

endpackage

@@ hw/rtl/sii_mac_lane.sv @@
module sii_mac_lane (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sii_pkg::lane_op_t                   op,
    input  logic signed [sii_pkg::OPND_W-1:0]   opa,
    input  logic signed [sii_pkg::OPND_W-1:0]   opb,
    input  logic signed [sii_pkg::ACC_W-1:0]    init,
    output logic signed [sii_pkg::ACC_W-1:0]    acc
);
    import sii_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  init_reg;
    lane_op_t                 op_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_x;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  base;

    // multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= '0;
        end
        else
        begin
            op_reg <= op;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
        init_reg <= init;
    end

    // round and accumulate stage
    always_comb
    begin
        prod_x = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        unique case (op_reg.shift)
            SH_NONE: term = prod_x;
            SH_19:   term = (prod_x + (68'sd1 <<< 18)) >>> 19;
            SH_30:   term = (prod_x + (68'sd1 <<< 29)) >>> 30;
            SH_32:   term = (prod_x + (68'sd1 <<< 31)) >>> 32;
            SH_33:   term = (prod_x + (68'sd1 <<< 32)) >>> 33;
            default: term = prod_x;
        endcase
        base     = op_reg.load ? init_reg : acc_reg;
        acc_next = op_reg.neg ? (base - term) : (base + term);
    end

    always_ff @(posedge clk)
    begin
        if (op_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

@@ hw/rtl/sii_norm.sv @@
module sii_norm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [63:0]        sum_sq,
    input  logic signed [31:0] h [3],
    output logic               done,
    output logic signed [31:0] dq [4]
);
    import sii_pkg::*;

    norm_state_t        state_reg, state_next;
    logic [ITER_W-1:0]  cnt_reg, cnt_next;
    logic               done_reg, done_next;

    logic [63:0]        rad_reg;
    logic [63:0]        root_reg;
    logic [63:0]        bit_reg;
    logic [64:0]        trial;
    logic [31:0]        n_reg;

    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = done_reg;
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    state_next = N_SQRT;
                    cnt_next   = '0;
                    done_next  = 1'b0;
                end
            end
            N_SQRT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ITER_W'(ITERS - 1))
                begin
                    state_next = N_DSET;
                end
            end
            N_DSET:
            begin
                state_next = N_DIV;
                cnt_next   = '0;
            end
            N_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ITER_W'(ITERS - 1))
                begin
                    state_next = N_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: state_next = N_IDLE;
        endcase
    end

    // square root, one result bit a cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == N_IDLE && start)
        begin
            rad_reg  <= sum_sq;
            root_reg <= '0;
            bit_reg  <= 64'd1 << 62;
        end
        else if (state_reg == N_SQRT)
        begin
            if ({1'b0, rad_reg} >= trial)
            begin
                rad_reg  <= rad_reg - trial[63:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (state_reg == N_DSET)
        begin
            n_reg <= root_reg[31:0];
        end
    end

    // four divider lanes: scalar part then the three vector parts
    for (genvar j = 0; j < 4; j++)
    begin : g_div
        logic [31:0] src_mag;
        logic        src_neg;
        logic [31:0] mag_reg;
        logic        neg_reg;
        logic [31:0] rem_reg;
        logic [31:0] lo_reg;
        logic [31:0] quo_reg;
        logic [63:0] dvd;
        logic [32:0] remsh;

        if (j == 0)
        begin : g_scalar
            assign src_mag = ONE_Q30;
            assign src_neg = 1'b0;
        end
        else
        begin : g_vec
            assign src_mag = h[j-1][31] ? (32'd0 - h[j-1]) : h[j-1];
            assign src_neg = h[j-1][31];
        end

        assign dvd   = {2'b0, mag_reg, 30'b0} + {33'b0, root_reg[31:1]};
        assign remsh = {rem_reg, lo_reg[31]};

        always_ff @(posedge clk)
        begin
            if (state_reg == N_IDLE && start)
            begin
                mag_reg <= src_mag;
                neg_reg <= src_neg;
            end
            else if (state_reg == N_DSET)
            begin
                rem_reg <= dvd[63:32];
                lo_reg  <= dvd[31:0];
            end
            else if (state_reg == N_DIV)
            begin
                if (remsh >= {1'b0, n_reg})
                begin
                    rem_reg <= 32'(remsh - {1'b0, n_reg});
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= remsh[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                lo_reg <= {lo_reg[30:0], 1'b0};
            end
        end

        assign dq[j] = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    end

    assign done = done_reg;

endmodule

@@ hw/rtl/strapdown_imu_integrator_top.sv @@
// one sample in flight: sample_stall holds new samples until the current one
//   is through, which is set by the bit-serial square root
//   and the four bit-serial dividers of the normaliser
// a first sample reloads the start state and gives no result
// reset: registers take their reset values, attitude is identity, velocity
//   and position are zero, no beat is pending
module strapdown_imu_integrator_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  sii_pkg::in_beat_t   sample,
    output logic                result_valid,
    input  logic                result_stall,
    output sii_pkg::out_beat_t  result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  sii_pkg::cfg_index_t cfg_index,
    input  logic [63:0]         cfg_data
);
    import sii_pkg::*;

    // sequencer step numbers
    localparam logic [4:0] S_H    = 5'd0;   // half angle and 0.5*dt^2
    localparam logic [4:0] S_HCAP = 5'd2;
    localparam logic [4:0] S_T0   = 5'd3;   // 1 + |h|^2 on lane 0, cross product on 1..3
    localparam logic [4:0] S_T1   = 5'd4;
    localparam logic [4:0] S_HH2  = 5'd5;
    localparam logic [4:0] S_TCAP = 5'd6;
    localparam logic [4:0] S_A0   = 5'd7;   // world acceleration, normaliser starts
    localparam logic [4:0] S_A1   = 5'd8;
    localparam logic [4:0] S_A2   = 5'd9;
    localparam logic [4:0] S_ACAP = 5'd11;
    localparam logic [4:0] S_P0   = 5'd12;  // position
    localparam logic [4:0] S_P1   = 5'd13;
    localparam logic [4:0] S_V0   = 5'd14;  // velocity
    localparam logic [4:0] S_PCAP = 5'd15;
    localparam logic [4:0] S_VCAP = 5'd16;
    localparam logic [4:0] S_Q0   = 5'd17;  // quaternion product, waits on normaliser
    localparam logic [4:0] S_Q1   = 5'd18;
    localparam logic [4:0] S_Q2   = 5'd19;
    localparam logic [4:0] S_Q3   = 5'd20;
    localparam logic [4:0] S_FIN  = 5'd22;

    // configuration registers
    logic [31:0]        step_time_reg;
    logic signed [47:0] start_pos_reg [3];
    logic signed [31:0] start_vel_reg [3];
    logic [63:0]        start_att_reg;

    // navigation state: attitude w,x,y,z
    logic signed [31:0] att_reg [4];
    logic signed [31:0] vel_reg [3];
    logic signed [47:0] pos_reg [3];

    // per-sample working registers
    in_beat_t           smp_reg;
    logic signed [31:0] h_reg [3];
    logic [31:0]        hdt2_reg;
    logic signed [31:0] t_reg [3];
    logic signed [31:0] a_reg [3];

    top_state_t         state_reg, state_next;
    logic [4:0]         step_reg, step_next;
    logic               out_valid_reg;
    out_beat_t          out_reg;

    logic               accept;
    logic               hold;
    logic               fin;

    // lane ports
    lane_op_t                 op_ctl  [NUM_LANES];
    logic signed [OPND_W-1:0] op_a    [NUM_LANES];
    logic signed [OPND_W-1:0] op_b    [NUM_LANES];
    logic signed [ACC_W-1:0]  op_init [NUM_LANES];
    logic signed [ACC_W-1:0]  acc     [NUM_LANES];

    logic               norm_done;
    logic signed [31:0] dq [4];

    logic signed [31:0] f [3];
    logic signed [31:0] r [3];
    logic signed [OPND_W-1:0] dt33;
    logic signed [31:0] w, ux, uy, uz;

    assign f[0] = smp_reg.force_x;
    assign f[1] = smp_reg.force_y;
    assign f[2] = smp_reg.force_z;
    assign r[0] = smp_reg.rate_x;
    assign r[1] = smp_reg.rate_y;
    assign r[2] = smp_reg.rate_z;
    assign dt33 = u33(step_time_reg);
    assign w    = att_reg[0];
    assign ux   = att_reg[1];
    assign uy   = att_reg[2];
    assign uz   = att_reg[3];

    // one sample in flight; the output register lets the next one start early
    assign sample_stall = (state_reg != ST_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // step holds while dq is not ready, or while the last beat is still waiting
    assign hold = (step_reg == S_Q0 && !norm_done)
                || (step_reg == S_FIN && out_valid_reg && result_stall);
    assign fin  = (state_reg == ST_RUN) && (step_reg == S_FIN) && !hold;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_time_reg <= 32'd21474837;
            for (int i = 0; i < 3; i++)
            begin
                start_pos_reg[i] <= '0;
                start_vel_reg[i] <= '0;
            end
            start_att_reg <= 64'd16384;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_STEP_TIME:   step_time_reg    <= cfg_data[31:0];
                REG_START_POS_X: start_pos_reg[0] <= cfg_data[47:0];
                REG_START_POS_Y: start_pos_reg[1] <= cfg_data[47:0];
                REG_START_POS_Z: start_pos_reg[2] <= cfg_data[47:0];
                REG_START_VEL_X: start_vel_reg[0] <= cfg_data[31:0];
                REG_START_VEL_Y: start_vel_reg[1] <= cfg_data[31:0];
                REG_START_VEL_Z: start_vel_reg[2] <= cfg_data[31:0];
                REG_START_ATT:   start_att_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !sample.first_sample)
                begin
                    state_next = ST_RUN;
                    step_next  = S_H;
                end
            end
            ST_RUN:
            begin
                if (fin)
                begin
                    state_next = ST_IDLE;
                end
                else if (!hold)
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // lane schedule: each lane takes at most one product per step
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            op_ctl[i]  = '0;
            op_a[i]    = '0;
            op_b[i]    = '0;
            op_init[i] = '0;
        end
        if (state_reg == ST_RUN)
        begin
            unique case (step_reg)
                S_H:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        op_ctl[i] = mk_op(1'b1, 1'b0, SH_19);
                        op_a[i]   = s33(r[i]);
                        op_b[i]   = dt33;
                    end
                    op_ctl[3] = mk_op(1'b1, 1'b0, SH_33);
                    op_a[3]   = dt33;
                    op_b[3]   = dt33;
                end
                S_T0:
                begin
                    op_ctl[0]  = mk_op(1'b1, 1'b0, SH_NONE);
                    op_a[0]    = s33(h_reg[0]);
                    op_b[0]    = s33(h_reg[0]);
                    op_init[0] = ONE_Q60;
                    op_ctl[1]  = mk_op(1'b1, 1'b0, SH_30);
                    op_a[1]    = s33(uy);
                    op_b[1]    = s33(f[2]);
                    op_ctl[2]  = mk_op(1'b1, 1'b0, SH_30);
                    op_a[2]    = s33(uz);
                    op_b[2]    = s33(f[0]);
                    op_ctl[3]  = mk_op(1'b1, 1'b0, SH_30);
                    op_a[3]    = s33(ux);
                    op_b[3]    = s33(f[1]);
                end
                S_T1:
                begin
                    op_ctl[0] = mk_op(1'b0, 1'b0, SH_NONE);
                    op_a[0]   = s33(h_reg[1]);
                    op_b[0]   = s33(h_reg[1]);
                    op_ctl[1] = mk_op(1'b0, 1'b1, SH_30);
                    op_a[1]   = s33(uz);
                    op_b[1]   = s33(f[1]);
                    op_ctl[2] = mk_op(1'b0, 1'b1, SH_30);
                    op_a[2]   = s33(ux);
                    op_b[2]   = s33(f[2]);
                    op_ctl[3] = mk_op(1'b0, 1'b1, SH_30);
                    op_a[3]   = s33(uy);
                    op_b[3]   = s33(f[0]);
                end
                S_HH2:
                begin
                    op_ctl[0] = mk_op(1'b0, 1'b0, SH_NONE);
                    op_a[0]   = s33(h_reg[2]);
                    op_b[0]   = s33(h_reg[2]);
                end
                S_A0:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        op_ctl[i+1] = mk_op(1'b1, 1'b0, SH_30);
                        op_a[i+1]   = s33(w);
                        op_b[i+1]   = s33(t_reg[i]);
                    end
                    op_init[1] = ext32(f[0]);
                    op_init[2] = ext32(f[1]);
                    op_init[3] = ext32(f[2]) - GRAVITY_Q16;
                end
                S_A1:
                begin
                    for (int i = 1; i < 4; i++)
                    begin
                        op_ctl[i] = mk_op(1'b0, 1'b0, SH_30);
                    end
                    op_a[1] = s33(uy);
                    op_b[1] = s33(t_reg[2]);
                    op_a[2] = s33(uz);
                    op_b[2] = s33(t_reg[0]);
                    op_a[3] = s33(ux);
                    op_b[3] = s33(t_reg[1]);
                end
                S_A2:
                begin
                    for (int i = 1; i < 4; i++)
                    begin
                        op_ctl[i] = mk_op(1'b0, 1'b1, SH_30);
                    end
                    op_a[1] = s33(uz);
                    op_b[1] = s33(t_reg[1]);
                    op_a[2] = s33(ux);
                    op_b[2] = s33(t_reg[2]);
                    op_a[3] = s33(uy);
                    op_b[3] = s33(t_reg[0]);
                end
                S_P0:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        op_ctl[i+1]  = mk_op(1'b1, 1'b0, SH_32);
                        op_a[i+1]    = s33(vel_reg[i]);
                        op_b[i+1]    = dt33;
                        op_init[i+1] = ext48(pos_reg[i]);
                    end
                end
                S_P1:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        op_ctl[i+1] = mk_op(1'b0, 1'b0, SH_32);
                        op_a[i+1]   = s33(a_reg[i]);
                        op_b[i+1]   = u33(hdt2_reg);
                    end
                end
                S_V0:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        op_ctl[i+1]  = mk_op(1'b1, 1'b0, SH_32);
                        op_a[i+1]    = s33(a_reg[i]);
                        op_b[i+1]    = dt33;
                        op_init[i+1] = ext32(vel_reg[i]);
                    end
                end
                S_Q0:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        op_ctl[i]       = mk_op(1'b1, 1'b0, SH_30);
                        op_ctl[i].valid = norm_done;
                        op_a[i]         = s33(w);
                        op_b[i]         = s33(dq[i]);
                    end
                end
                S_Q1:
                begin
                    op_ctl[0] = mk_op(1'b0, 1'b1, SH_30);
                    op_ctl[1] = mk_op(1'b0, 1'b0, SH_30);
                    op_ctl[2] = mk_op(1'b0, 1'b0, SH_30);
                    op_ctl[3] = mk_op(1'b0, 1'b0, SH_30);
                    op_a[0]   = s33(ux);
                    op_b[0]   = s33(dq[1]);
                    op_a[1]   = s33(ux);
                    op_b[1]   = s33(dq[0]);
                    op_a[2]   = s33(uy);
                    op_b[2]   = s33(dq[0]);
                    op_a[3]   = s33(uz);
                    op_b[3]   = s33(dq[0]);
                end
                S_Q2:
                begin
                    op_ctl[0] = mk_op(1'b0, 1'b1, SH_30);
                    op_ctl[1] = mk_op(1'b0, 1'b0, SH_30);
                    op_ctl[2] = mk_op(1'b0, 1'b0, SH_30);
                    op_ctl[3] = mk_op(1'b0, 1'b0, SH_30);
                    op_a[0]   = s33(uy);
                    op_b[0]   = s33(dq[2]);
                    op_a[1]   = s33(uy);
                    op_b[1]   = s33(dq[3]);
                    op_a[2]   = s33(uz);
                    op_b[2]   = s33(dq[1]);
                    op_a[3]   = s33(ux);
                    op_b[3]   = s33(dq[2]);
                end
                S_Q3:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        op_ctl[i] = mk_op(1'b0, 1'b1, SH_30);
                    end
                    op_a[0] = s33(uz);
                    op_b[0] = s33(dq[3]);
                    op_a[1] = s33(uz);
                    op_b[1] = s33(dq[2]);
                    op_a[2] = s33(ux);
                    op_b[2] = s33(dq[3]);
                    op_a[3] = s33(uy);
                    op_b[3] = s33(dq[1]);
                end
                default: ;
            endcase
        end
    end

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        sii_mac_lane u_lane (
            .clk  (clk),
            .rst_n(rst_n),
            .op   (op_ctl[i]),
            .opa  (op_a[i]),
            .opb  (op_b[i]),
            .init (op_init[i]),
            .acc  (acc[i])
        );
    end

    sii_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_RUN && step_reg == S_A0),
        .sum_sq(acc[0][63:0]),
        .h     (h_reg),
        .done  (norm_done),
        .dq    (dq)
    );

    // merge: saturate lane sums into the working registers (hdt2 is truncated)
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smp_reg <= sample;
        end
        if (state_reg == ST_RUN)
        begin
            unique case (step_reg)
                S_HCAP:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        h_reg[i] <= sat32(acc[i]);
                    end
                    hdt2_reg <= acc[3][31:0];
                end
                S_TCAP:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        t_reg[i] <= sat32(acc[i+1] <<< 1);
                    end
                end
                S_ACAP:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        a_reg[i] <= sat32(acc[i+1]);
                    end
                end
                default: ;
            endcase
        end
    end

    // navigation state and result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            att_reg[0] <= 32'sh40000000;
            for (int i = 1; i < 4; i++)
            begin
                att_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                vel_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept && sample.first_sample)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    att_reg[i] <= {start_att_reg[16*i +: 16], 16'b0};
                end
                for (int i = 0; i < 3; i++)
                begin
                    vel_reg[i] <= start_vel_reg[i];
                    pos_reg[i] <= start_pos_reg[i];
                end
            end
            if (state_reg == ST_RUN && step_reg == S_PCAP)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pos_reg[i] <= sat48(acc[i+1]);
                end
            end
            if (state_reg == ST_RUN && step_reg == S_VCAP)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    vel_reg[i] <= sat32(acc[i+1]);
                end
            end
            if (fin)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    att_reg[i] <= sat32(acc[i]);
                end
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            out_reg.out_time_tag <= smp_reg.time_tag;
            out_reg.pos_x        <= pos_reg[0];
            out_reg.pos_y        <= pos_reg[1];
            out_reg.pos_z        <= pos_reg[2];
            out_reg.quat_w       <= sat32(acc[0]);
            out_reg.quat_x       <= sat32(acc[1]);
            out_reg.quat_y       <= sat32(acc[2]);
            out_reg.quat_z       <= sat32(acc[3]);
        end
    end

    // a new beat only ever comes out of the last step
    a_beat_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_RUN && step_reg == S_FIN))
        else $error("result beat raised outside the final step");

    // the quaternion product only runs on a finished normaliser
    a_dq_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && step_reg > S_Q0 && step_reg <= S_FIN) |-> norm_done)
        else $error("quaternion product used dq before the normaliser finished");

    // a first sample only reloads the state
    a_first_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sample.first_sample) |=> (state_reg == ST_IDLE))
        else $error("first sample started an integration step");

endmodule
